@@ hw/rtl/surge_yaw_thrust_merge_top_defines.svh @@
// Assertion macros for the surge and yaw thrust limiter top level.
`ifndef SURGE_YAW_THRUST_MERGE_TOP_DEFINES_SVH
`define SURGE_YAW_THRUST_MERGE_TOP_DEFINES_SVH

// Implication checked at every rising clock edge outside reset.
`define SYT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Invariant checked at every rising clock edge outside reset.
`define SYT_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

`endif

@@ hw/rtl/syt_pkg.sv @@
// Types, constants and the divider step shared by the thrust limiter modules.
package syt_pkg;

  localparam int FIELD_W = 20;
  localparam int FORCE_W = 17;
  localparam int ARM_W   = 15;
  localparam int YLIM_W  = 19;
  localparam int IDX_W   = 2;
  localparam int ARM_FRAC = 14;
  localparam int YLIM_SHIFT = 13;

  localparam int QUOT_W = 18;
  localparam int REM_W  = 34;
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES = QUOT_W / BITS_PER_STAGE;

  localparam logic [IDX_W-1:0] REG_PUSH = 2'd0;
  localparam logic [IDX_W-1:0] REG_PULL = 2'd1;
  localparam logic [IDX_W-1:0] REG_ARM  = 2'd2;

  localparam int PushRst = 23040;
  localparam int PullRst = 25600;
  localparam int ArmRst  = 8356;
  localparam int YlimRst = ((PushRst < PullRst ? PushRst : PullRst) * ArmRst) / 8192;

  localparam logic [FORCE_W-1:0] PUSH_RST = FORCE_W'(PushRst);
  localparam logic [FORCE_W-1:0] PULL_RST = FORCE_W'(PullRst);
  localparam logic [ARM_W-1:0]   ARM_RST  = ARM_W'(ArmRst);
  localparam logic [YLIM_W-1:0]  YLIM_RST = YLIM_W'(YlimRst);

  typedef struct packed {
    logic [FORCE_W-1:0] push;
    logic [FORCE_W-1:0] pull;
    logic [ARM_W-1:0]   arm;
    logic [YLIM_W-1:0]  ylim;
  } cfg_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] surge;
    logic signed [FIELD_W-1:0] yaw;
  } side_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [QUOT_W-1:0] quot;
  } div_t;

  // One restoring step: tries to take arm shifted to the given quotient bit.
  function automatic div_t div_step(div_t a, logic [ARM_W-1:0] arm, int unsigned bitpos);
    div_t r;
    logic [REM_W-1:0] dsh;
    r   = a;
    dsh = REM_W'(arm) << bitpos;
    if (a.rem >= dsh) begin
      r.rem = a.rem - dsh;
      r.quot[bitpos] = 1'b1;
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/syt_in_if.sv @@
// Request channel carrying surge and yaw demands.
interface syt_in_if;
  logic                      valid;
  logic                      ready;
  logic signed [19:0]        surge_in;
  logic signed [19:0]        yaw_in;

  modport source (output valid, output surge_in, output yaw_in, input ready);
  modport sink   (input valid, input surge_in, input yaw_in, output ready);
endinterface

@@ hw/rtl/syt_out_if.sv @@
// Result channel carrying the limited surge and yaw.
interface syt_out_if;
  logic                      valid;
  logic                      ready;
  logic signed [19:0]        surge_out;
  logic signed [19:0]        yaw_out;

  modport source (output valid, output surge_out, output yaw_out, input ready);
  modport sink   (input valid, input surge_out, input yaw_out, output ready);
endinterface

@@ hw/rtl/syt_cfg.sv @@
// Configuration registers and the derived yaw limit.
module syt_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [syt_pkg::IDX_W-1:0]    cfg_idx_i,
  input  logic [syt_pkg::FORCE_W-1:0]  cfg_data_i,
  output syt_pkg::cfg_t                cfg_o
);
  import syt_pkg::*;

  logic [FORCE_W-1:0] push_q, pull_q;
  logic [ARM_W-1:0]   arm_q;
  logic [YLIM_W-1:0]  ylim_q, ylim_d;
  logic [FORCE_W-1:0] lesser_force;
  logic [FORCE_W+ARM_W-1:0] prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push_q <= PUSH_RST;
      pull_q <= PULL_RST;
      arm_q  <= ARM_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PUSH: push_q <= cfg_data_i;
        REG_PULL: pull_q <= cfg_data_i;
        REG_ARM:  arm_q  <= cfg_data_i[ARM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    lesser_force = (push_q < pull_q) ? push_q : pull_q;
    prod         = (FORCE_W+ARM_W)'(lesser_force) * (FORCE_W+ARM_W)'(arm_q);
    ylim_d       = prod[YLIM_SHIFT +: YLIM_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ylim_q <= YLIM_RST;
    end else begin
      ylim_q <= ylim_d;
    end
  end

  assign cfg_o = '{push: push_q, pull: pull_q, arm: arm_q, ylim: ylim_q};
endmodule

@@ hw/rtl/syt_front.sv @@
// Input register, surge and yaw clamping, and dividend forming.
module syt_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  syt_pkg::cfg_t                      cfg_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [syt_pkg::FIELD_W-1:0] in_surge_i,
  input  logic signed [syt_pkg::FIELD_W-1:0] in_yaw_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [syt_pkg::REM_W-1:0]          out_rem_o,
  output syt_pkg::side_t                     out_side_o
);
  import syt_pkg::*;

  logic va_q, vb_q, vc_q;
  logic en_a, en_b, en_c;
  side_t raw_q, clamp_q, clamp_d, side_c_q;
  logic [REM_W-1:0] rem_q, rem_d;

  logic signed [FIELD_W:0] s_ext, y_ext, push2, pull2, ylim_ext, y_abs;
  logic [FIELD_W-1:0] ay;

  assign en_c = !vc_q || out_ready_i;
  assign en_b = !vb_q || en_c;
  assign en_a = !va_q || en_b;
  assign in_ready_o = en_a;

  always_comb begin
    s_ext    = (FIELD_W+1)'(raw_q.surge);
    y_ext    = (FIELD_W+1)'(raw_q.yaw);
    push2    = signed'({3'b000, cfg_i.push, 1'b0});
    pull2    = signed'({3'b000, cfg_i.pull, 1'b0});
    ylim_ext = signed'({2'b00, cfg_i.ylim});
    if (s_ext > push2) begin
      s_ext = push2;
    end else if (s_ext < -pull2) begin
      s_ext = -pull2;
    end
    if (y_ext > ylim_ext) begin
      y_ext = ylim_ext;
    end else if (y_ext < -ylim_ext) begin
      y_ext = -ylim_ext;
    end
    clamp_d.surge = s_ext[FIELD_W-1:0];
    clamp_d.yaw   = y_ext[FIELD_W-1:0];
  end

  always_comb begin
    y_abs = (FIELD_W+1)'(clamp_q.yaw);
    if (y_abs < 0) begin
      y_abs = -y_abs;
    end
    ay = y_abs[FIELD_W-1:0];
    if (cfg_i.arm == '0) begin
      rem_d = '0;
    end else begin
      rem_d = {ay, {ARM_FRAC{1'b0}}} + REM_W'(cfg_i.arm) - REM_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (en_a) va_q <= in_valid_i;
      if (en_b) vb_q <= va_q;
      if (en_c) vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      raw_q.surge <= in_surge_i;
      raw_q.yaw   <= in_yaw_i;
    end
    if (en_b) clamp_q <= clamp_d;
    if (en_c) begin
      side_c_q <= clamp_q;
      rem_q    <= rem_d;
    end
  end

  assign out_valid_o = vc_q;
  assign out_rem_o   = rem_q;
  assign out_side_o  = side_c_q;
endmodule

@@ hw/rtl/syt_div.sv @@
// Pipelined restoring divider that yields the rounded-up thrust difference.
module syt_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [syt_pkg::ARM_W-1:0]     arm_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [syt_pkg::REM_W-1:0]     in_rem_i,
  input  syt_pkg::side_t                in_side_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [syt_pkg::QUOT_W-1:0]    out_quot_o,
  output syt_pkg::side_t                out_side_o
);
  import syt_pkg::*;

  logic  v_q    [DIV_STAGES];
  div_t  acc_q  [DIV_STAGES];
  side_t side_q [DIV_STAGES];
  logic  en     [DIV_STAGES+1];

  always_comb begin
    en[DIV_STAGES] = out_ready_i;
    for (int k = DIV_STAGES - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    div_t  acc_in, acc_d;
    logic  v_in;
    side_t side_in;

    if (j == 0) begin : g_first
      assign acc_in  = '{rem: in_rem_i, quot: '0};
      assign v_in    = in_valid_i;
      assign side_in = in_side_i;
    end else begin : g_next
      assign acc_in  = acc_q[j-1];
      assign v_in    = v_q[j-1];
      assign side_in = side_q[j-1];
    end

    always_comb begin
      acc_d = acc_in;
      for (int b = 0; b < BITS_PER_STAGE; b++) begin
        acc_d = div_step(acc_d, arm_i, QUOT_W - 1 - j * BITS_PER_STAGE - b);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en[j]) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[j]) begin
        acc_q[j]  <= acc_d;
        side_q[j] <= side_in;
      end
    end
  end

  assign out_valid_o = v_q[DIV_STAGES-1];
  assign out_quot_o  = acc_q[DIV_STAGES-1].quot;
  assign out_side_o  = side_q[DIV_STAGES-1];
endmodule

@@ hw/rtl/surge_yaw_thrust_merge_top.sv @@
// Throughput: one item per cycle while the output is ready; the nine-stage divider
// pipeline sets the depth. A stalled output holds each stage that has no free stage
// after it, while free stages keep filling.
// Reset clears all pipeline valid bits and loads the limit registers with
// their defaults; the derived yaw limit is reset to match.
module surge_yaw_thrust_merge_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [syt_pkg::IDX_W-1:0]    cfg_idx_i,
  input  logic [syt_pkg::FORCE_W-1:0]  cfg_data_i,
  syt_in_if.sink                       in_i,
  syt_out_if.source                    out_o
);
  import syt_pkg::*;
  `include "surge_yaw_thrust_merge_top_defines.svh"

  cfg_t cfg;

  logic             fr_valid, fr_ready;
  logic [REM_W-1:0] fr_rem;
  side_t            fr_side;

  logic              dv_valid, dv_ready;
  logic [QUOT_W-1:0] dv_quot;
  side_t             dv_side;

  logic out_v_q;
  logic signed [FIELD_W-1:0] surge_q, surge_d, yaw_q;
  logic signed [FIELD_W:0] s_ext, d_ext, push2, pull2, hi_room, lo_room, sum;
  logic [QUOT_W-1:0] dceil;

  logic signed [FIELD_W:0] ylim_ext, surge_ext;
  logic yaw_ok, surge_ok, pipe_full;

  syt_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  syt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_surge_i  (in_i.surge_in),
    .in_yaw_i    (in_i.yaw_in),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_rem_o   (fr_rem),
    .out_side_o  (fr_side)
  );

  syt_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .arm_i       (cfg.arm),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_rem_i    (fr_rem),
    .in_side_i   (fr_side),
    .out_valid_o (dv_valid),
    .out_ready_i (dv_ready),
    .out_quot_o  (dv_quot),
    .out_side_o  (dv_side)
  );

  assign dv_ready = !out_v_q || out_o.ready;

  // The surge moves only as far as needed to keep both thrusters within limits.
  always_comb begin
    dceil   = (cfg.arm == '0) ? '0 : dv_quot;
    s_ext   = (FIELD_W+1)'(dv_side.surge);
    d_ext   = signed'({3'b000, dceil});
    push2   = signed'({3'b000, cfg.push, 1'b0});
    pull2   = signed'({3'b000, cfg.pull, 1'b0});
    hi_room = push2 - s_ext;
    lo_room = s_ext + pull2;
    if (d_ext > hi_room) begin
      sum = push2 - d_ext;
    end else if (d_ext > lo_room) begin
      sum = d_ext - pull2;
    end else begin
      sum = s_ext;
    end
    surge_d = sum[FIELD_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (dv_ready) begin
      out_v_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dv_ready) begin
      surge_q <= surge_d;
      yaw_q   <= dv_side.yaw;
    end
  end

  assign out_o.valid     = out_v_q;
  assign out_o.surge_out = surge_q;
  assign out_o.yaw_out   = yaw_q;

  assign ylim_ext  = signed'({2'b00, cfg.ylim});
  assign surge_ext = (FIELD_W+1)'(surge_q);
  assign yaw_ok    = (yaw_q <= ylim_ext) && (yaw_q >= -ylim_ext);
  assign surge_ok  = (surge_ext <= push2) && (surge_ext >= -pull2);
  assign pipe_full = out_v_q && !out_o.ready && dv_valid && fr_valid;

  `SYT_ASSERT_ALWAYS(a_yaw_in_limit, !out_v_q || yaw_ok, "yaw result exceeds the yaw limit")
  `SYT_ASSERT_IMP(a_surge_in_range, out_v_q, surge_ok, "surge result outside the thrust range")
  `SYT_ASSERT_IMP(a_stall_only_when_full, !in_i.ready, pipe_full, "input stalled with room left")
endmodule

@@ tb/sv/surge_yaw_thrust_merge_top_tb.sv @@
// Self-checking testbench for the surge and yaw thrust limiter across several limit settings.
module surge_yaw_thrust_merge_top_tb;
  import syt_pkg::*;

  localparam int NPHASE = 11;
  localparam int PHASE_ITEMS = 140;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;
  localparam longint FIELD_MAX = 524287;
  localparam longint FIELD_MIN = -524288;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [IDX_W-1:0] cfg_idx_i;
  logic [FORCE_W-1:0] cfg_data_i;

  syt_in_if req_if ();
  syt_out_if res_if ();

  surge_yaw_thrust_merge_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (req_if),
    .out_o      (res_if)
  );

  longint push_lim = PushRst;
  longint pull_lim = PullRst;
  longint arm_len = ArmRst;

  side_t pending_demands[$];
  side_t results_due[$];
  side_t want;
  int queued_cnt = 0;
  int checked_cnt = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int send_gap = 0;
  int stall_left = 0;
  bit calm = 1'b0;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic longint yaw_limit();
    longint minf;
    minf = push_lim < pull_lim ? push_lim : pull_lim;
    return (minf * arm_len) / (longint'(1) << YLIM_SHIFT);
  endfunction

  function automatic side_t limit_demand(logic signed [FIELD_W-1:0] surge_req,
                                         logic signed [FIELD_W-1:0] yaw_req);
    longint s, y, ylim, ay, num, span, dceil, sum, yaw;
    side_t r;
    s = surge_req;
    y = yaw_req;
    ylim = yaw_limit();
    if (s > 2 * push_lim) s = 2 * push_lim;
    if (s < -2 * pull_lim) s = -2 * pull_lim;
    if (y > ylim) y = ylim;
    if (y < -ylim) y = -ylim;
    ay = y < 0 ? -y : y;
    num = ay * (longint'(1) << ARM_FRAC);
    span = (push_lim + pull_lim) * arm_len;
    sum = s;
    yaw = y;
    if (num > span) begin
      // Both sides pinned; unreachable while the yaw limit rounds down.
      sum = push_lim - pull_lim;
      yaw = span / (longint'(1) << ARM_FRAC);
      if (y < 0) yaw = -yaw;
    end else if (ay != 0 && arm_len > 0) begin
      dceil = (num + arm_len - 1) / arm_len;
      if (s * arm_len + num > 2 * push_lim * arm_len) begin
        sum = 2 * push_lim - dceil;
      end else if (s * arm_len - num < -2 * pull_lim * arm_len) begin
        sum = -2 * pull_lim + dceil;
      end
    end
    r.surge = FIELD_W'(sum);
    r.yaw = FIELD_W'(yaw);
    return r;
  endfunction

  function automatic logic signed [FIELD_W-1:0] pick_force(longint span);
    longint v, lim;
    lim = span > FIELD_MAX ? FIELD_MAX : span;
    case ($urandom_range(0, 5))
      0, 1: v = longint'($urandom_range(0, 1048575)) + FIELD_MIN;
      2: v = longint'($urandom_range(0, 2 * lim)) - lim;
      3: begin
        v = lim + longint'($urandom_range(0, 64)) - 32;
        if ($urandom_range(0, 1)) v = -v;
      end
      4: v = longint'($urandom_range(0, 512)) - 256;
      default: begin
        case ($urandom_range(0, 2))
          0: v = FIELD_MAX;
          1: v = FIELD_MIN;
          default: v = 0;
        endcase
      end
    endcase
    if (v > FIELD_MAX) v = FIELD_MAX;
    if (v < FIELD_MIN) v = FIELD_MIN;
    return FIELD_W'(v);
  endfunction

  task automatic queue_demand(longint s, longint y);
    side_t d;
    d.surge = FIELD_W'(s);
    d.yaw = FIELD_W'(y);
    pending_demands.push_back(d);
    queued_cnt++;
  endtask

  task automatic drain();
    while (checked_cnt < queued_cnt) @(posedge clk_i);
  endtask

  task automatic program_limits(longint push, longint pull, longint arm);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_PUSH;
    cfg_data_i <= FORCE_W'(push);
    @(posedge clk_i);
    cfg_idx_i <= REG_PULL;
    cfg_data_i <= FORCE_W'(pull);
    @(posedge clk_i);
    cfg_idx_i <= REG_ARM;
    cfg_data_i <= FORCE_W'(arm);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    push_lim = push;
    pull_lim = pull;
    arm_len = arm;
  endtask

  // Sender: transfers queued demands and predicts each accepted one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.surge_in <= '0;
      req_if.yaw_in <= '0;
      send_gap <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        results_due.push_back(limit_demand(req_if.surge_in, req_if.yaw_in));
      end
      if (req_if.valid && !req_if.ready) begin
        req_if.valid <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        req_if.valid <= 1'b0;
      end else if (pending_demands.size() != 0) begin
        if (!calm && $urandom_range(0, 7) == 0) begin
          send_gap <= $urandom_range(0, 10);
          req_if.valid <= 1'b0;
        end else begin
          want = pending_demands.pop_front();
          req_if.valid <= 1'b1;
          req_if.surge_in <= want.surge;
          req_if.yaw_in <= want.yaw;
        end
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  side_t got_expect;

  // Receiver: checks every result transfer against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        checked_cnt = checked_cnt + 1;
        if (results_due.size() == 0) begin
          $error("result transfer with no request outstanding: surge_out %0d, yaw_out %0d",
                 res_if.surge_out, res_if.yaw_out);
          mismatches = mismatches + 1;
        end else begin
          got_expect = results_due.pop_front();
          if (res_if.surge_out !== got_expect.surge) begin
            $error("surge_out: expected %0d, actual %0d", got_expect.surge, res_if.surge_out);
            mismatches = mismatches + 1;
          end
          if (res_if.yaw_out !== got_expect.yaw) begin
            $error("yaw_out: expected %0d, actual %0d", got_expect.yaw, res_if.yaw_out);
            mismatches = mismatches + 1;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        res_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 10);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("surge_yaw_thrust_merge_top regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  longint plan_push [NPHASE] = '{PushRst, 131071, 0, 0, 23040, 5000, 131071, 1, 0, 0, PushRst};
  longint plan_pull [NPHASE] = '{PullRst, 131071, 0, 25600, 0, 5000, 1, 131071, 0, 0, PullRst};
  longint plan_arm  [NPHASE] = '{ArmRst, 32767, 1, 8356, 8356, 0, 1, 32767, 0, 0, ArmRst};

  initial begin
    longint ylim, sspan;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_PUSH;
    cfg_data_i = '0;
    req_if.valid = 1'b0;
    req_if.surge_in = '0;
    req_if.yaw_in = '0;
    res_if.ready = 1'b0;
    plan_push[8] = $urandom_range(0, 131071);
    plan_pull[8] = $urandom_range(0, 131071);
    plan_arm[8] = $urandom_range(1, 32767);
    plan_push[9] = $urandom_range(0, 8191);
    plan_pull[9] = $urandom_range(0, 8191);
    plan_arm[9] = $urandom_range(1, 32767);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    ylim = yaw_limit();
    queue_demand(0, 0);
    queue_demand(FIELD_MAX, 0);
    queue_demand(FIELD_MIN, 0);
    queue_demand(0, FIELD_MAX);
    queue_demand(0, FIELD_MIN);
    queue_demand(FIELD_MAX, FIELD_MAX);
    queue_demand(FIELD_MIN, FIELD_MIN);
    queue_demand(FIELD_MAX, FIELD_MIN);
    queue_demand(FIELD_MIN, FIELD_MAX);
    queue_demand(2 * push_lim, 0);
    queue_demand(-2 * pull_lim, 0);
    queue_demand(2 * push_lim, ylim);
    queue_demand(-2 * pull_lim, -ylim);
    queue_demand(40000, 20000);
    queue_demand(-45000, -20000);
    queue_demand(1, 1);
    queue_demand(-1, -1);
    queue_demand(0, ylim + 1);
    queue_demand(0, -ylim - 1);
    queue_demand(push_lim - pull_lim, ylim);

    for (int ph = 0; ph < NPHASE; ph++) begin
      if (ph != 0) begin
        drain();
        if (ph == NPHASE - 1) calm = 1'b1;
        program_limits(plan_push[ph], plan_pull[ph], plan_arm[ph]);
      end
      ylim = yaw_limit();
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        sspan = $urandom_range(0, 1) ? 2 * push_lim : 2 * pull_lim;
        if ($urandom_range(0, 9) == 0) begin
          queue_demand(pick_force(sspan), 0);
        end else begin
          queue_demand(pick_force(sspan), pick_force(ylim));
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Sent %0d demands through %0d limit settings, zero limits and zero arm among them.",
             queued_cnt, NPHASE);
    $display("Checked %0d results under random gaps and stalls on both channels.", checked_cnt);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("surge_yaw_thrust_merge_top regression: pass");
    end else begin
      $display("surge_yaw_thrust_merge_top regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/syt_pkg.sv
hw/rtl/syt_in_if.sv
hw/rtl/syt_out_if.sv
hw/rtl/syt_cfg.sv
hw/rtl/syt_front.sv
hw/rtl/syt_div.sv
hw/rtl/surge_yaw_thrust_merge_top.sv
tb/sv/surge_yaw_thrust_merge_top_tb.sv
